// File: hdl/stdt_pkg.sv
// shared types and constants for the stereo disparity triangulator
package stdt_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASELINE  = 3'd0,
    REG_FOCAL     = 3'd1,
    REG_PRINC_U   = 3'd2,
    REG_PRINC_V   = 3'd3,
    REG_MIN_DISP  = 3'd4
  } stdt_reg_t;

  localparam logic [31:0] BASELINE_RST = 32'hFE800000;
  localparam logic [15:0] FOCAL_RST    = 16'd8192;
  localparam logic [15:0] PRINC_U_RST  = 16'd5120;
  localparam logic [15:0] PRINC_V_RST  = 16'd3840;
  localparam logic [15:0] MIN_DISP_RST = 16'd16;

  // classified keypoint pair handed from front to back
  typedef struct packed {
    logic               rej;
    logic        [15:0] disp;
    logic signed [16:0] du;
    logic signed [16:0] dv;
  } stdt_item_t;

endpackage

// File: hdl/stereo_disparity_triangulator.sv
// top level of the stereo disparity triangulator
//   channel   handshake                 payload
//   input     push / full               left_x, left_y, right_x
//   result    empty / pop               ok, point_x, point_y, point_z
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
// one pair per cycle sustained while results are popped; a pair reaches the result ports through
// the queue, operand register, product stage, 33 divider stages and result register
// rst clears the queue, the pipeline valids and the registers to their defaults
// a result not popped stalls the whole back end; the front queue of four keeps taking pairs until it is full
module stereo_disparity_triangulator
  import stdt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [15:0]          left_x,
  input  logic [15:0]          left_y,
  input  logic [15:0]          right_x,
  output logic                 empty,
  input  logic                 pop,
  output logic                 ok,
  output logic [31:0]          point_x,
  output logic [31:0]          point_y,
  output logic [31:0]          point_z,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [31:0] baseline_times_focal;
  logic [15:0] focal_length;
  logic [15:0] principal_u;
  logic [15:0] principal_v;
  logic [15:0] min_disparity;

  stdt_item_t item;
  logic       item_valid;
  logic       item_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_times_focal <= BASELINE_RST;
      focal_length         <= FOCAL_RST;
      principal_u          <= PRINC_U_RST;
      principal_v          <= PRINC_V_RST;
      min_disparity        <= MIN_DISP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASELINE: baseline_times_focal <= cfg_data;
        REG_FOCAL:    focal_length         <= cfg_data[15:0];
        REG_PRINC_U:  principal_u          <= cfg_data[15:0];
        REG_PRINC_V:  principal_v          <= cfg_data[15:0];
        REG_MIN_DISP: min_disparity        <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  stdt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .left_x        (left_x),
    .left_y        (left_y),
    .right_x       (right_x),
    .focal_length  (focal_length),
    .principal_u   (principal_u),
    .principal_v   (principal_v),
    .min_disparity (min_disparity),
    .item          (item),
    .item_valid    (item_valid),
    .item_pop      (item_pop)
  );

  stdt_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .item                 (item),
    .item_valid           (item_valid),
    .item_pop             (item_pop),
    .baseline_times_focal (baseline_times_focal),
    .focal_length         (focal_length),
    .empty                (empty),
    .pop                  (pop),
    .ok                   (ok),
    .point_x              (point_x),
    .point_y              (point_y),
    .point_z              (point_z)
  );

`ifndef SYNTH
  a_rej_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !ok) |-> (point_x == 32'd0 && point_y == 32'd0 && point_z == 32'd0))
    else $error("rejected pair with nonzero coordinates");

  a_depth_sign: assert property (@(posedge clk) disable iff (rst)
    (!empty && ok && baseline_times_focal[31]) |-> !point_z[31])
    else $error("depth sign disagrees with baseline sign");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result present right after reset");
`endif

endmodule

// File: hdl/stdt_front.sv
// front end: accepts keypoint pairs, classifies them and queues them for the back end
module stdt_front
  import stdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] left_x,
  input  logic [15:0] left_y,
  input  logic [15:0] right_x,
  input  logic [15:0] focal_length,
  input  logic [15:0] principal_u,
  input  logic [15:0] principal_v,
  input  logic [15:0] min_disparity,
  output stdt_item_t  item,
  output logic        item_valid,
  input  logic        item_pop
);

  localparam int QD = 4;
  localparam int PW = $clog2(QD);

  stdt_item_t    q_mem [QD];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   cnt;

  logic signed [16:0] disp_s;
  stdt_item_t         cls;
  logic               wr;
  logic               rd;

  always_comb begin
    disp_s  = $signed({1'b0, left_x}) - $signed({1'b0, right_x});
    cls.disp = disp_s[15:0];
    cls.du   = $signed({1'b0, left_x}) - $signed({1'b0, principal_u});
    cls.dv   = $signed({1'b0, left_y}) - $signed({1'b0, principal_v});
    // non-positive disparity always rejected, as is a zero focal length
    cls.rej  = disp_s[16] || (disp_s == 17'sd0) || (disp_s[15:0] < min_disparity)
               || (focal_length == 16'd0);
  end

  assign full       = (cnt == (PW+1)'(QD));
  assign item_valid = (cnt != '0);
  assign item       = q_mem[rp];
  assign wr         = push && !full;
  assign rd         = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      q_mem[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + 1'b1;
      end
      if (rd) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

endmodule

// File: hdl/stdt_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module stdt_div
  import stdt_pkg::*;
#(
  parameter int NW = 54,
  parameter int DW = 33,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  localparam int RW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [RW-1:0] rem [QW];
  logic [DW-1:0] dvs [QW];
  logic [QW-1:0] qb  [1:QW];
  logic          ov  [1:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(num);
      dvs[0] <= den;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int SH = QW - k;
    logic [RW:0] diff;
    logic        hit;

    assign diff = {1'b0, rem[k-1]} - ({1'b0, RW'(dvs[k-1])} << SH);
    assign hit  = !diff[RW];

    if (k < QW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= hit ? diff[RW-1:0] : rem[k-1];
          dvs[k] <= dvs[k-1];
        end
      end
    end

    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          qb[k] <= QW'(hit) << SH;
          ov[k] <= rem[0] >= (RW'(dvs[0]) << QW);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          qb[k] <= qb[k-1] | (QW'(hit) << SH);
          ov[k] <= ov[k-1];
        end
      end
    end
  end

  assign quo = qb[QW];
  assign ovf = ov[QW];

endmodule

// File: hdl/stdt_back.sv
// back end: products, three pipelined dividers, rounding, saturation and result register
module stdt_back
  import stdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  stdt_item_t  item,
  input  logic        item_valid,
  output logic        item_pop,
  input  logic [31:0] baseline_times_focal,
  input  logic [15:0] focal_length,
  output logic        empty,
  input  logic        pop,
  output logic        ok,
  output logic [31:0] point_x,
  output logic [31:0] point_y,
  output logic [31:0] point_z
);

  localparam int QW  = 32;
  localparam int LAT = QW + 1;

  typedef struct packed {
    logic vld;
    logic rej;
    logic negx;
    logic negy;
    logic negz;
  } stdt_side_t;

  logic en;

  // stage a
  logic       a_vld;
  stdt_item_t a_item;

  // stage m
  stdt_side_t  m_side;
  logic [47:0] m_mx;
  logic [47:0] m_my;
  logic [31:0] m_dxy;
  logic [31:0] m_magb;
  logic [15:0] m_disp;

  stdt_side_t side [LAT];

  logic [31:0] magb;
  logic        bpos;
  logic [15:0] mag_u;
  logic [15:0] mag_v;

  logic [QW-1:0] qx, qy, qz;
  logic          ox, oy, oz;
  logic          rvalid;

  function automatic logic [31:0] sat(input logic [QW-1:0] q, input logic o, input logic neg);
    logic        big;
    logic [31:0] m;
    if (neg) begin
      big = o || (q[31] && (|q[30:0]));
      m   = big ? 32'h80000000 : q;
      return -m;
    end
    big = o || q[31];
    return big ? 32'h7FFFFFFF : q;
  endfunction

  assign en       = !rvalid || pop;
  assign item_pop = en && item_valid;
  assign empty    = !rvalid;

  assign magb  = baseline_times_focal[31] ? -baseline_times_focal : baseline_times_focal;
  assign bpos  = !baseline_times_focal[31] && (|baseline_times_focal);
  assign mag_u = a_item.du[16] ? 16'(-a_item.du) : a_item.du[15:0];
  assign mag_v = a_item.dv[16] ? 16'(-a_item.dv) : a_item.dv[15:0];

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= item;
      m_mx   <= magb * mag_u;
      m_my   <= magb * mag_v;
      m_dxy  <= a_item.disp * focal_length;
      m_magb <= magb;
      m_disp <= a_item.disp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld  <= 1'b0;
      m_side <= '0;
      for (int i = 0; i < LAT; i++) begin
        side[i] <= '0;
      end
    end else if (en) begin
      a_vld       <= item_valid;
      m_side.vld  <= a_vld;
      m_side.rej  <= a_item.rej;
      m_side.negz <= bpos;
      m_side.negx <= bpos ^ a_item.du[16];
      m_side.negy <= bpos ^ a_item.dv[16];
      side[0]     <= m_side;
      for (int i = 1; i < LAT; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // rounding to nearest: floor((2*mag + den) / (2*den))
  stdt_div #(.NW(54), .DW(33), .QW(QW)) u_div_x (
    .clk (clk),
    .en  (en),
    .num ({1'b0, m_mx, 5'b0} + 54'(m_dxy)),
    .den ({m_dxy, 1'b0}),
    .quo (qx),
    .ovf (ox)
  );

  stdt_div #(.NW(54), .DW(33), .QW(QW)) u_div_y (
    .clk (clk),
    .en  (en),
    .num ({1'b0, m_my, 5'b0} + 54'(m_dxy)),
    .den ({m_dxy, 1'b0}),
    .quo (qy),
    .ovf (oy)
  );

  stdt_div #(.NW(38), .DW(17), .QW(QW)) u_div_z (
    .clk (clk),
    .en  (en),
    .num ({1'b0, m_magb, 5'b0} + 38'(m_disp)),
    .den ({m_disp, 1'b0}),
    .quo (qz),
    .ovf (oz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else if (en) begin
      rvalid <= side[LAT-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok      <= !side[LAT-1].rej;
      point_x <= side[LAT-1].rej ? 32'd0 : sat(qx, ox, side[LAT-1].negx);
      point_y <= side[LAT-1].rej ? 32'd0 : sat(qy, oy, side[LAT-1].negy);
      point_z <= side[LAT-1].rej ? 32'd0 : sat(qz, oz, side[LAT-1].negz);
    end
  end

endmodule

// File: tb/sv/stereo_disparity_triangulator_checker.sv
// checker for the stereo disparity triangulator: predicts points and compares results
`timescale 1ns / 1ps
module stereo_disparity_triangulator_checker
  import stdt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  logic [15:0]          left_x,
  input  logic [15:0]          left_y,
  input  logic [15:0]          right_x,
  input  logic                 empty,
  input  logic                 pop,
  input  logic                 ok,
  input  logic [31:0]          point_x,
  input  logic [31:0]          point_y,
  input  logic [31:0]          point_z,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   errors,
  output int                   pending
);

  typedef struct packed {
    logic        ok;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } point_t;

  point_t      point_q[$];
  logic [31:0] baseline;
  logic [15:0] focal, pu, pv, min_disp;

  assign pending = point_q.size();

  // rounded half away from zero, saturated to 32 bits
  function automatic logic [31:0] round_div(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    if (num < 0) begin
      if (q > 64'sd2147483648) q = 64'sd2147483648;
      return 32'(-q);
    end
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    return 32'(q);
  endfunction

  function automatic point_t triangulate(logic [15:0] lx, logic [15:0] ly, logic [15:0] rx);
    point_t p;
    longint d, nb, den;
    p = '0;
    d = longint'(lx) - longint'(rx);
    if (d <= 0 || d < longint'(min_disp) || focal == 0) return p;
    nb = -longint'($signed(baseline)) * 16;
    den = d * longint'(focal);
    p.ok = 1'b1;
    p.px = round_div(nb * (longint'(lx) - longint'(pu)), den);
    p.py = round_div(nb * (longint'(ly) - longint'(pv)), den);
    p.pz = round_div(nb, d);
    return p;
  endfunction

  always @(posedge clk) begin
    point_t e;
    if (rst) begin
      baseline <= BASELINE_RST;
      focal    <= FOCAL_RST;
      pu       <= PRINC_U_RST;
      pv       <= PRINC_V_RST;
      min_disp <= MIN_DISP_RST;
      errors   <= 0;
      point_q.delete();
    end else begin
      if (push && !full) point_q.push_back(triangulate(left_x, left_y, right_x));
      if (pop && !empty) begin
        if (point_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result transaction");
        end else begin
          e = point_q.pop_front();
          if (e != {ok, point_x, point_y, point_z}) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: exp ok=%0b x=%h y=%h z=%h got ok=%0b x=%h y=%h z=%h",
                       e.ok, e.px, e.py, e.pz, ok, point_x, point_y, point_z);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASELINE: baseline <= cfg_data;
          REG_FOCAL:    focal    <= cfg_data[15:0];
          REG_PRINC_U:  pu       <= cfg_data[15:0];
          REG_PRINC_V:  pv       <= cfg_data[15:0];
          REG_MIN_DISP: min_disp <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: tb/sv/stereo_disparity_triangulator_tb.sv
// testbench top: stimulus, configuration phases and verdict for the triangulator
`timescale 1ns / 1ps
module stereo_disparity_triangulator_tb;
  import stdt_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0, pop = 1'b0, cfg_valid = 1'b0;
  logic [15:0]          left_x = '0, left_y = '0, right_x = '0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 full, empty, ok, cfg_ready;
  logic [31:0]          point_x, point_y, point_z;
  int                   errors, pending;
  int                   send_idle = 0, recv_idle = 0;
  bit                   hold_recv = 1'b0;

  always #1 clk = ~clk;

  stereo_disparity_triangulator i_dut (.*);
  stereo_disparity_triangulator_checker i_chk (.*);

  // receiver: random pop, with optional long hold-off
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= !hold_recv && ($urandom_range(99) >= recv_idle);
  end

  // push stays high into the next call so pairs can go back to back
  task automatic send_pair(logic [15:0] lx, logic [15:0] ly, logic [15:0] rx);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    left_x <= lx;
    left_y <= ly;
    right_x <= rx;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(stdt_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_pair();
    logic [15:0] lx, rx;
    lx = 16'($urandom);
    rx = ($urandom_range(3) == 0) ? 16'($urandom) : lx - 16'($urandom_range(2000));
    send_pair(lx, 16'($urandom), rx);
  endtask

  initial begin
    #1000000;
    $display("stereo_disparity_triangulator test failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, low and non-positive disparity, saturation
    send_pair(16'hFFFF, 16'hFFFF, 16'h0000);
    send_pair(16'h0000, 16'h0000, 16'h0000);
    send_pair(16'h1000, 16'h0800, 16'h1000);
    send_pair(16'h0100, 16'h0800, 16'h0200);
    send_pair(16'h1010, 16'h0F00, 16'h1000);
    send_pair(16'h100F, 16'h0F00, 16'h1000);
    send_pair(16'h1001, 16'h0000, 16'h1000);
    send_pair(16'h2000, 16'hFFFF, 16'h1000);
    drain();
    write_reg(REG_MIN_DISP, 32'd0);
    write_reg(REG_BASELINE, 32'h8000_0000);
    send_pair(16'h0001, 16'h0000, 16'h0000);
    send_pair(16'hFFFF, 16'hFFFF, 16'hFFFE);
    send_pair(16'h0005, 16'h0005, 16'h0005);
    drain();
    write_reg(REG_BASELINE, 32'h7FFF_FFFF);
    write_reg(REG_FOCAL, 32'd1);
    write_reg(REG_PRINC_U, 32'hFFFF);
    write_reg(REG_PRINC_V, 32'd0);
    send_pair(16'h0001, 16'hFFFF, 16'h0000);
    send_pair(16'hFFFF, 16'h0000, 16'h0000);
    drain();
    write_reg(REG_FOCAL, 32'hFFFF);
    write_reg(REG_MIN_DISP, 32'hFFFF);
    send_pair(16'hFFFF, 16'h1234, 16'h0000);
    send_pair(16'hFFFE, 16'h1234, 16'h0000);
    drain();
    write_reg(REG_FOCAL, 32'd0);
    write_reg(REG_MIN_DISP, 32'd0);
    send_pair(16'h2000, 16'h1000, 16'h1000);
    drain();
    // random phases, each with its own configuration
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_BASELINE, (ph == 3) ? BASELINE_RST : $urandom);
      write_reg(REG_FOCAL, (ph == 3) ? 32'(FOCAL_RST) : $urandom_range(65535, 1));
      write_reg(REG_PRINC_U, $urandom_range(65535));
      write_reg(REG_PRINC_V, $urandom_range(65535));
      write_reg(REG_MIN_DISP, $urandom_range(64));
      send_idle = (ph == 0) ? 30 : (ph == 1) ? 67 : 0;
      recv_idle = (ph == 0) ? 67 : (ph == 1) ? 30 : 0;
      for (int n = 0; n < 500; n++) random_pair();
      drain();
    end
    // receiver holds off long enough that the block fills and stalls input
    fork
      begin
        hold_recv = 1'b1;
        repeat (200) @(posedge clk);
        hold_recv = 1'b0;
      end
      for (int n = 0; n < 60; n++) random_pair();
    join
    drain();
    if (errors == 0 && pending == 0)
      $display("stereo_disparity_triangulator test passed");
    else
      $display("stereo_disparity_triangulator test failed");
    $finish;
  end

endmodule
